// File: hdl/lsab_pkg.sv
package lsab_pkg;

  localparam int unsigned BIN_COUNT_DEF = 360;
  localparam int unsigned ANGLE_W = 25;
  localparam int unsigned CM_W = 13;

  // An all-ones distance marks a bin that holds no sample.
  localparam logic [CM_W-1:0] CM_UNDEF = '1;

  localparam logic signed [27:0] FULL_TURN = 28'sd23592960;
  localparam logic signed [27:0] FULL_TURN2 = 28'sd47185920;
  localparam logic [ANGLE_W-1:0] HALF_DEG = 25'd32768;

  localparam logic [16:0] CM_RECIP = 17'd52429;

  localparam logic [15:0] MIN_RANGE_RST = 16'd50;
  localparam logic [15:0] MAX_RANGE_RST = 16'd12000;
  localparam logic [25:0] ANGLE_START_RST = 26'd0;
  localparam logic [25:0] ANGLE_STEP_RST = 26'd65536;
  localparam logic [24:0] ANGLE_OFFSET_RST = 25'd983040;
  localparam logic [15:0] TIMEOUT_RST = 16'd300;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_COMMIT = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_READ   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    REG_MIN_RANGE     = 3'd0,
    REG_MAX_RANGE     = 3'd1,
    REG_ANGLE_START   = 3'd2,
    REG_ANGLE_STEP    = 3'd3,
    REG_ANGLE_OFFSET  = 3'd4,
    REG_FRESH_TIMEOUT = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [15:0]        min_mm;
    logic [15:0]        max_mm;
    logic [ANGLE_W-1:0] step_w;
    logic [15:0]        timeout;
    logic [ANGLE_W-1:0] base_angle;
    logic [ANGLE_W-1:0] base_next;
    logic               reload;
  } cfg_t;

  // Brings an angle within two turns either side back into one turn.
  function automatic logic [ANGLE_W-1:0] wrap_turn(input logic signed [27:0] a);
    logic signed [27:0] cand [5];
    logic [ANGLE_W-1:0] res;
    cand[0] = a - FULL_TURN2;
    cand[1] = a - FULL_TURN;
    cand[2] = a;
    cand[3] = a + FULL_TURN;
    cand[4] = a + FULL_TURN2;
    res = '0;
    for (int i = 0; i < 5; i++) begin
      if (cand[i] >= 28'sd0 && cand[i] < FULL_TURN) begin
        res = cand[i][ANGLE_W-1:0];
      end
    end
    return res;
  endfunction

endpackage

// File: hdl/lsab_ram.sv
module lsab_ram
  import lsab_pkg::*;
#(
  parameter int unsigned WIDTH = CM_W,
  parameter int unsigned DEPTH = BIN_COUNT_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/lsab_cfg.sv
module lsab_cfg
  import lsab_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [15:0]        min_q;
  logic [15:0]        max_q;
  logic [25:0]        start_q;
  logic [25:0]        step_q;
  logic [24:0]        offset_q;
  logic [15:0]        timeout_q;
  logic [ANGLE_W-1:0] step_w_q;
  logic [ANGLE_W-1:0] base_q;
  logic [ANGLE_W-1:0] base_d;
  logic [25:0]        start_n;
  logic [24:0]        offset_n;
  logic [2:0]         idx;
  logic               wr;
  logic               reload;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign reload = wr && (idx == REG_ANGLE_START || idx == REG_ANGLE_OFFSET);

  assign start_n  = (wr && idx == REG_ANGLE_START) ? pwdata[25:0] : start_q;
  assign offset_n = (wr && idx == REG_ANGLE_OFFSET) ? pwdata[24:0] : offset_q;
  assign base_d   = wrap_turn($signed({{2{start_n[25]}}, start_n}) +
                              $signed({3'b000, offset_n}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q     <= MIN_RANGE_RST;
      max_q     <= MAX_RANGE_RST;
      start_q   <= ANGLE_START_RST;
      step_q    <= ANGLE_STEP_RST;
      offset_q  <= ANGLE_OFFSET_RST;
      timeout_q <= TIMEOUT_RST;
      step_w_q  <= ANGLE_STEP_RST[ANGLE_W-1:0];
      base_q    <= ANGLE_OFFSET_RST;
    end else if (wr) begin
      case (idx)
        REG_MIN_RANGE:     min_q <= pwdata[15:0];
        REG_MAX_RANGE:     max_q <= pwdata[15:0];
        REG_ANGLE_START: begin
          start_q <= pwdata[25:0];
          base_q  <= base_d;
        end
        REG_ANGLE_STEP: begin
          step_q   <= pwdata[25:0];
          step_w_q <= wrap_turn($signed({{2{pwdata[25]}}, pwdata[25:0]}));
        end
        REG_ANGLE_OFFSET: begin
          offset_q <= pwdata[24:0];
          base_q   <= base_d;
        end
        REG_FRESH_TIMEOUT: timeout_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MIN_RANGE:     prdata = {16'b0, min_q};
      REG_MAX_RANGE:     prdata = {16'b0, max_q};
      REG_ANGLE_START:   prdata = {6'b0, start_q};
      REG_ANGLE_STEP:    prdata = {6'b0, step_q};
      REG_ANGLE_OFFSET:  prdata = {7'b0, offset_q};
      REG_FRESH_TIMEOUT: prdata = {16'b0, timeout_q};
      default:           prdata = '0;
    endcase
  end

  assign cfg_o.min_mm     = min_q;
  assign cfg_o.max_mm     = max_q;
  assign cfg_o.step_w     = step_w_q;
  assign cfg_o.timeout    = timeout_q;
  assign cfg_o.base_angle = base_q;
  assign cfg_o.base_next  = base_d;
  assign cfg_o.reload     = reload;

endmodule

// File: hdl/lsab_angle.sv
module lsab_angle
  import lsab_pkg::*;
#(
  parameter int unsigned BIN_COUNT = BIN_COUNT_DEF,
  localparam int unsigned AW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  logic          sample_i,
  input  logic          commit_i,
  output logic [AW-1:0] bin_o
);

  localparam int unsigned RECIP = ((1 << 20) + BIN_COUNT - 1) / BIN_COUNT;

  logic [ANGLE_W-1:0] acc_q;
  logic [ANGLE_W-1:0] acc_d;
  logic [ANGLE_W-1:0] rnd;
  logic [8:0]         deg;
  logic [29:0]        prod;
  logic [9:0]         quo;
  logic [19:0]        qn;
  logic [10:0]        rem;

  always_comb begin
    acc_d = acc_q;
    if (cfg_i.reload) begin
      acc_d = cfg_i.base_next;
    end else if (commit_i) begin
      acc_d = cfg_i.base_angle;
    end else if (sample_i) begin
      acc_d = wrap_turn($signed({3'b000, acc_q}) + $signed({3'b000, cfg_i.step_w}));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= ANGLE_OFFSET_RST;
    end else begin
      acc_q <= acc_d;
    end
  end

  // Whole degrees, halves up, then folded into the bin range by reciprocal.
  assign rnd   = acc_q + HALF_DEG;
  assign deg   = rnd[24:16];
  assign prod  = 30'(deg) * 30'(RECIP);
  assign quo   = prod[29:20];
  assign qn    = 20'(quo) * 20'(BIN_COUNT);
  assign rem   = 11'(deg) - qn[10:0];
  assign bin_o = rem[AW-1:0];

endmodule

// File: hdl/lidar_scan_angle_binner.sv
// A request is registered in the request stage and its result in the output stage, which offers it.
// Throughput: one request per cycle while the output is not stalled and no clearing pass
// runs, set by the read-modify-write of the working bin memory, which forwards the last
// write when two samples hit the same bin. After reset the block clears both bin memories,
// after every end-of-scan request the new working one, and accepts no request meanwhile.
// Reset is asynchronous and active low; configuration writes are taken at all times.
module lidar_scan_angle_binner
  import lsab_pkg::*;
#(
  parameter int unsigned BIN_COUNT = BIN_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // range_mm[15:0], bin_index[24:16]
  input  logic [2:0]  s_axis_tuser,  // action[1:0], range_finite[2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // distance_cm[12:0]
  output logic [1:0]  m_axis_tuser,  // bin_defined[0], fresh[1]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

  cfg_t            cfg;
  logic            in_acc;
  action_e         act_in;
  logic [15:0]     range_in;
  logic [9:0]      idx_in;
  logic            keep_in;
  logic [32:0]     cm_prod;
  logic [CM_W-1:0] cm_in;
  logic [AW-1:0]   sample_bin;
  logic [AW-1:0]   rd_addr;
  logic            inr_in;

  logic            s1_valid_q;
  action_e         s1_act_q;
  logic            s1_keep_q;
  logic [CM_W-1:0] s1_cm_q;
  logic [AW-1:0]   s1_addr_q;
  logic            s1_inr_q;
  logic            s1_fresh_q;
  logic            fwd_hit_q;
  logic            fwd_hit_d;
  logic [CM_W-1:0] fwd_data_q;
  logic            s1_adv;

  logic            sel_q;
  logic            clr_q;
  logic [1:0]      clr_mask_q;
  logic [AW-1:0]   clr_cnt_q;
  logic            has_q;
  logic [16:0]     age_q;
  logic            has_n;
  logic [16:0]     age_n;
  logic            fresh_n;

  logic [CM_W-1:0] ram_rdata [2];
  logic [AW-1:0]   ram_raddr [2];
  logic [AW-1:0]   ram_waddr [2];
  logic [CM_W-1:0] ram_wdata [2];
  logic            ram_we [2];

  logic [CM_W-1:0] old_val;
  logic [CM_W-1:0] new_val;
  logic [CM_W-1:0] pub_val;
  logic            upd;
  logic            wb_we;
  logic            rd_def;

  logic            out_valid_q;
  logic [CM_W-1:0] out_dist_q;
  logic            out_def_q;
  logic            out_fresh_q;

  lsab_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  lsab_angle #(.BIN_COUNT(BIN_COUNT)) u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .sample_i(in_acc && act_in == ACT_SAMPLE),
    .commit_i(in_acc && act_in == ACT_COMMIT),
    .bin_o   (sample_bin)
  );

  assign act_in   = action_e'(s_axis_tuser[1:0]);
  assign range_in = s_axis_tdata[15:0];
  assign idx_in   = {1'b0, s_axis_tdata[24:16]};
  assign keep_in  = s_axis_tuser[2] && range_in > cfg.min_mm && range_in < cfg.max_mm;
  assign cm_prod  = 33'(range_in) * 33'(CM_RECIP);
  assign cm_in    = cm_prod[31:19];
  assign rd_addr  = idx_in[AW-1:0];
  assign inr_in   = 11'(idx_in) < 11'(BIN_COUNT);

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !clr_q && (!s1_valid_q || s1_adv);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign has_n   = (act_in == ACT_COMMIT) ? 1'b1 : has_q;
  always_comb begin
    age_n = age_q;
    if (act_in == ACT_COMMIT) begin
      age_n = '0;
    end else if (act_in == ACT_TICK && age_q != '1) begin
      age_n = age_q + 17'd1;
    end
  end
  assign fresh_n = has_n && (age_n <= {1'b0, cfg.timeout});

  for (genvar k = 0; k < 2; k++) begin : g_bank
    assign ram_raddr[k] = (sel_q == 1'(k)) ? sample_bin : rd_addr;
    assign ram_we[k]    = (clr_q && clr_mask_q[k]) || (wb_we && sel_q == 1'(k));
    assign ram_waddr[k] = clr_q ? clr_cnt_q : s1_addr_q;
    assign ram_wdata[k] = clr_q ? CM_UNDEF : s1_cm_q;

    lsab_ram #(.WIDTH(CM_W), .DEPTH(BIN_COUNT)) u_ram (
      .clk_i  (clk_i),
      .we_i   (ram_we[k]),
      .waddr_i(ram_waddr[k]),
      .wdata_i(ram_wdata[k]),
      .re_i   (in_acc),
      .raddr_i(ram_raddr[k]),
      .rdata_o(ram_rdata[k])
    );
  end

  assign old_val = fwd_hit_q ? fwd_data_q : ram_rdata[sel_q];
  assign upd     = s1_valid_q && s1_act_q == ACT_SAMPLE && s1_keep_q && s1_cm_q < old_val;
  assign new_val = upd ? s1_cm_q : old_val;
  assign wb_we   = s1_adv && upd;

  assign fwd_hit_d = s1_valid_q && s1_act_q == ACT_SAMPLE && s1_keep_q &&
                     act_in == ACT_SAMPLE && sample_bin == s1_addr_q;

  assign pub_val = ram_rdata[!sel_q];
  assign rd_def  = s1_act_q == ACT_READ && s1_fresh_q && s1_inr_q && pub_val != CM_UNDEF;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
      clr_q       <= 1'b1;
      clr_mask_q  <= 2'b11;
      clr_cnt_q   <= '0;
      has_q       <= 1'b0;
      age_q       <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        fwd_hit_q  <= fwd_hit_d;
        has_q      <= has_n;
        age_q      <= age_n;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
        fwd_hit_q  <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc && act_in == ACT_COMMIT) begin
        sel_q      <= !sel_q;
        clr_q      <= 1'b1;
        clr_mask_q <= sel_q ? 2'b01 : 2'b10;
        clr_cnt_q  <= '0;
      end else if (clr_q) begin
        if (clr_cnt_q == AW'(BIN_COUNT - 1)) begin
          clr_q     <= 1'b0;
          clr_cnt_q <= '0;
        end else begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_act_q   <= act_in;
      s1_keep_q  <= keep_in;
      s1_cm_q    <= cm_in;
      s1_addr_q  <= (act_in == ACT_SAMPLE) ? sample_bin : rd_addr;
      s1_inr_q   <= inr_in;
      s1_fresh_q <= fresh_n;
      fwd_data_q <= new_val;
    end
    if (s1_adv) begin
      out_dist_q  <= rd_def ? pub_val : '0;
      out_def_q   <= rd_def;
      out_fresh_q <= s1_fresh_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_dist_q};
  assign m_axis_tuser  = {out_fresh_q, out_def_q};

  a_commit_clears_working: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser[1:0] == ACT_COMMIT)
      |=> (clr_q && clr_mask_q[sel_q] && !clr_mask_q[!sel_q]))
    else $error("end of scan did not start clearing the new working bank");

  a_no_write_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_we |-> !clr_q)
    else $error("sample write collided with the clearing pass");

  a_defined_is_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tuser[1])
    else $error("defined bin reported on stale data");

  a_fwd_from_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> (s1_valid_q && s1_act_q == ACT_SAMPLE))
    else $error("forwarded bin value on a request that is not a sample");

endmodule

// File: bench/lidar_scan_angle_binner_tb.sv
`timescale 1ns / 1ps

module lidar_scan_angle_binner_tb
  import lsab_pkg::*;
;

  localparam int unsigned BINS = BIN_COUNT_DEF;
  localparam longint TURN_UNITS = 23592960;
  localparam int unsigned AGE_CEILING = 131071;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct packed {
    action_e     action;
    logic        finite;
    logic [8:0]  bin_index;
    logic [15:0] range_mm;
  } bin_req_t;

  typedef struct packed {
    logic [CM_W-1:0] distance_cm;
    logic            bin_defined;
    logic            fresh;
  } bin_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // range_mm[15:0], bin_index[24:16]
  logic [2:0]  s_axis_tuser = '0;   // action[1:0], range_finite[2]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // distance_cm[12:0]
  logic [1:0]  m_axis_tuser;        // bin_defined[0], fresh[1]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lidar_scan_angle_binner DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  bin_req_t    req_q[$];
  bin_req_t    cur_req = '0;
  bin_result_t bin_result_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  // Shadow of the block: configuration, bin stores, angle and freshness.
  logic [15:0]     min_mm, max_mm, timeout;
  longint          start_ang, step_ang;
  logic [24:0]     offset_ang, angle_acc;
  logic [CM_W-1:0] work_cm [BINS];
  bit              work_ok [BINS];
  logic [CM_W-1:0] pub_cm [BINS];
  bit              pub_ok [BINS];
  bit              scan_seen;
  int unsigned     age;

  function automatic logic [24:0] wrap_to_turn(longint a);
    longint r;
    r = a % TURN_UNITS;
    if (r < 0) begin
      r += TURN_UNITS;
    end
    return r[24:0];
  endfunction

  function automatic void reload_angle();
    angle_acc = wrap_to_turn(start_ang + longint'(offset_ang));
  endfunction

  function automatic bit data_fresh();
    return scan_seen && age <= timeout;
  endfunction

  function automatic void reset_model();
    min_mm = 16'd50;
    max_mm = 16'd12000;
    start_ang = 0;
    step_ang = 65536;
    offset_ang = 25'd983040;
    timeout = 16'd300;
    for (int i = 0; i < BINS; i++) begin
      work_cm[i] = '0;
      work_ok[i] = 1'b0;
      pub_cm[i] = '0;
      pub_ok[i] = 1'b0;
    end
    scan_seen = 1'b0;
    age = 0;
    reload_angle();
  endfunction

  function automatic void apply_reg(reg_idx_e idx, logic [31:0] v);
    case (idx)
      REG_MIN_RANGE: begin
        min_mm = v[15:0];
      end
      REG_MAX_RANGE: begin
        max_mm = v[15:0];
      end
      REG_ANGLE_START: begin
        start_ang = longint'(signed'(v[25:0]));
        reload_angle();
      end
      REG_ANGLE_STEP: begin
        step_ang = longint'(signed'(v[25:0]));
      end
      REG_ANGLE_OFFSET: begin
        offset_ang = v[24:0];
        reload_angle();
      end
      REG_FRESH_TIMEOUT: begin
        timeout = v[15:0];
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void predict_bin_result(bin_req_t r);
    bin_result_t     res;
    int unsigned     b;
    logic [CM_W-1:0] cm;
    res = '0;
    case (r.action)
      ACT_SAMPLE: begin
        if (r.finite && r.range_mm > min_mm && r.range_mm < max_mm) begin
          b = ((32'(angle_acc) + 32'd32768) >> 16) % BINS;
          cm = CM_W'(r.range_mm / 16'd10);
          if (!work_ok[b] || cm < work_cm[b]) begin
            work_cm[b] = cm;
            work_ok[b] = 1'b1;
          end
        end
        angle_acc = wrap_to_turn(longint'(angle_acc) + step_ang);
      end
      ACT_COMMIT: begin
        for (int i = 0; i < BINS; i++) begin
          pub_cm[i] = work_cm[i];
          pub_ok[i] = work_ok[i];
          work_cm[i] = '0;
          work_ok[i] = 1'b0;
        end
        scan_seen = 1'b1;
        age = 0;
        reload_angle();
      end
      ACT_TICK: begin
        if (age < AGE_CEILING) begin
          age++;
        end
      end
      default: begin
        if (data_fresh() && r.bin_index < BINS && pub_ok[r.bin_index]) begin
          res.distance_cm = pub_cm[r.bin_index];
          res.bin_defined = 1'b1;
        end
      end
    endcase
    res.fresh = data_fresh();
    bin_result_q.push_back(res);
  endfunction

  function automatic void push_req(action_e a, int unsigned rng, bit fin, int unsigned idx);
    bin_req_t r;
    r.action = a;
    r.range_mm = 16'(rng);
    r.finite = fin;
    r.bin_index = 9'(idx);
    req_q.push_back(r);
  endfunction

  function automatic logic [31:0] field26(int v);
    logic [25:0] t;
    t = v[25:0];
    return {6'd0, t};
  endfunction

  function automatic int unsigned pick_range();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 80 && int'(max_mm) > int'(min_mm) + 1) begin
      return $urandom_range(int'(min_mm) + 1, int'(max_mm) - 1);
    end
    if (sel < 86) begin
      return min_mm;
    end
    if (sel < 92) begin
      return max_mm;
    end
    return $urandom_range(65535);
  endfunction

  function automatic int unsigned pick_bin();
    if ($urandom_range(9) == 0) begin
      return $urandom_range(511, BINS);
    end
    return $urandom_range(BINS - 1);
  endfunction

  // Mostly whole scans followed by reads and ticks; the rest is loose requests.
  function automatic void gen_scans(int unsigned n);
    int unsigned made;
    int unsigned k;
    made = 0;
    while (made < n) begin
      if ($urandom_range(99) < 80) begin
        k = $urandom_range(120, 5);
        repeat (k) begin
          push_req(ACT_SAMPLE, pick_range(), $urandom_range(19) != 0, $urandom_range(511));
        end
        push_req(ACT_COMMIT, $urandom_range(65535), $urandom_range(1), $urandom_range(511));
        made += k + 1;
        k = $urandom_range(25, 3);
        repeat (k) begin
          push_req(($urandom_range(3) == 0) ? ACT_TICK : ACT_READ, $urandom_range(65535),
                   $urandom_range(1), pick_bin());
        end
        made += k;
      end else begin
        k = $urandom_range(10, 1);
        repeat (k) begin
          push_req(action_e'($urandom_range(3)), $urandom_range(65535), $urandom_range(1),
                   $urandom_range(511));
        end
        made += k;
      end
    end
  endfunction

  task automatic cfg_write(reg_idx_e idx, logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    apply_reg(idx, v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (req_q.size() != 0 || s_axis_tvalid || bin_result_q.size() != 0);
  endtask

  task automatic setup_phase(int unsigned p);
    logic [31:0] mn, mx, st, sp, of, tm;
    mn = $urandom_range(500);
    mx = $urandom_range(65535, 2000);
    st = $urandom() & 32'h3FFFFFF;
    sp = $urandom() & 32'h3FFFFFF;
    of = $urandom() & 32'h1FFFFFF;
    tm = $urandom_range(20);
    case (p)
      0: begin
        mn = 0;
        mx = 65535;
        sp = field26(65536);
        of = 0;
        tm = 65535;
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        st = field26(-23592960);
        sp = field26(16384);
        of = 23592959;
        send_idle_pct = 48;
        recv_stall_pct = 0;
      end
      2: begin
        mx = $urandom_range(20000, 2000);
        st = field26(23592960);
        sp = field26(-196608);
        tm = 5;
        send_idle_pct = 0;
        recv_stall_pct = 48;
      end
      3: begin
        mn = $urandom_range(2000);
        mx = $urandom_range(65535);
        tm = $urandom_range(65535);
        send_idle_pct = 11;
        recv_stall_pct = 11;
      end
      4: begin
        mn = 65535;
        mx = 0;
        sp = field26(-23592959);
        tm = 1;
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      5: begin
        st = field26(-33554432);
        sp = field26(23592959);
        of = 33554431;
        send_idle_pct = 48;
        recv_stall_pct = 0;
      end
      6: begin
        mn = $urandom_range(1000);
        tm = $urandom_range(30);
        send_idle_pct = 0;
        recv_stall_pct = 48;
      end
      default: begin
        mn = $urandom_range(1000);
        sp = field26($urandom_range(4 * 65536) - 2 * 65536);
        send_idle_pct = 11;
        recv_stall_pct = 11;
      end
    endcase
    cfg_write(REG_MIN_RANGE, mn);
    cfg_write(REG_MAX_RANGE, mx);
    cfg_write(REG_ANGLE_START, st);
    cfg_write(REG_ANGLE_STEP, sp);
    cfg_write(REG_ANGLE_OFFSET, of);
    cfg_write(REG_FRESH_TIMEOUT, tm);
  endtask

  always @(posedge clk_i) begin : request_driver
    bin_req_t nxt;
    if (s_axis_tvalid && s_axis_tready) begin
      predict_bin_result(cur_req);
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (rst_ni && req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = req_q.pop_front();
        cur_req <= nxt;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, nxt.bin_index, nxt.range_mm};
        s_axis_tuser <= {nxt.finite, nxt.action};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    bin_result_t want;
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (bin_result_q.size() == 0) begin
        mismatch_cnt++;
        $error("result with no request outstanding: distance_cm %0d", m_axis_tdata[12:0]);
      end else begin
        want = bin_result_q.pop_front();
        if (m_axis_tdata[12:0] !== want.distance_cm) begin
          mismatch_cnt++;
          $error("distance_cm: expected %0d, actual %0d", want.distance_cm,
                 m_axis_tdata[12:0]);
        end
        if (m_axis_tuser[0] !== want.bin_defined) begin
          mismatch_cnt++;
          $error("bin_defined: expected %0d, actual %0d", want.bin_defined, m_axis_tuser[0]);
        end
        if (m_axis_tuser[1] !== want.fresh) begin
          mismatch_cnt++;
          $error("fresh: expected %0d, actual %0d", want.fresh, m_axis_tuser[1]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: range limits on both sides, a request that is not finite,
    // reads before any scan and beyond the last bin.
    push_req(ACT_READ, 0, 1'b0, 5);
    push_req(ACT_SAMPLE, 50, 1'b1, 0);
    push_req(ACT_SAMPLE, 51, 1'b1, 0);
    push_req(ACT_SAMPLE, 11999, 1'b1, 0);
    push_req(ACT_SAMPLE, 12000, 1'b1, 0);
    push_req(ACT_SAMPLE, 65535, 1'b1, 0);
    push_req(ACT_SAMPLE, 1000, 1'b0, 0);
    push_req(ACT_COMMIT, 0, 1'b0, 0);
    push_req(ACT_READ, 0, 1'b0, 16);
    push_req(ACT_READ, 0, 1'b0, 17);
    push_req(ACT_READ, 0, 1'b0, 20);
    push_req(ACT_READ, 0, 1'b0, 359);
    push_req(ACT_READ, 0, 1'b0, 360);
    push_req(ACT_READ, 65535, 1'b1, 511);
    push_req(ACT_TICK, 0, 1'b0, 0);
    push_req(ACT_READ, 0, 1'b0, 16);
    wait_drained();

    // Half a degree short of a full turn rounds into the first bin; a zero timeout
    // goes stale on the first tick.
    cfg_write(REG_MIN_RANGE, 0);
    cfg_write(REG_MAX_RANGE, 65535);
    cfg_write(REG_ANGLE_OFFSET, 0);
    cfg_write(REG_ANGLE_START, field26(23592960 - 32768));
    cfg_write(REG_ANGLE_STEP, field26(-1));
    cfg_write(REG_FRESH_TIMEOUT, 0);
    push_req(ACT_SAMPLE, 65534, 1'b1, 0);
    push_req(ACT_SAMPLE, 1, 1'b1, 0);
    push_req(ACT_SAMPLE, 0, 1'b1, 0);
    push_req(ACT_COMMIT, 0, 1'b0, 0);
    push_req(ACT_READ, 0, 1'b0, 0);
    push_req(ACT_READ, 0, 1'b0, 359);
    push_req(ACT_TICK, 0, 1'b0, 0);
    push_req(ACT_READ, 0, 1'b0, 0);
    wait_drained();

    for (int unsigned p = 0; p < 8; p++) begin
      setup_phase(p);
      gen_scans(215);
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
